/* design/bir_pkg.sv */
`default_nettype none
package bir_pkg;
  localparam int unsigned MaxSrcWidth  = 256;
  localparam int unsigned MaxSrcHeight = 256;
  localparam int unsigned MaxChannels  = 4;
  localparam int unsigned FracBits     = 16;
  localparam int unsigned XW   = $clog2(MaxSrcWidth);
  localparam int unsigned YW   = $clog2(MaxSrcHeight);
  localparam int unsigned AW   = XW + YW;
  localparam int unsigned DW   = 8 * MaxChannels;
  localparam int unsigned NCH_W = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DW = 24;
  // accumulator width for fixed-point cubic evaluation
  localparam int unsigned PW = 48;

  // result scaling: 36 * 2^16 = 9 * 2^18, the nine by reciprocal multiplication
  localparam int unsigned ValShift    = 18;
  localparam int unsigned ValSat      = 256 * 9;
  localparam int unsigned Recip9      = 3641;
  localparam int unsigned Recip9Shift = 15;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y     = 3'd4;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  typedef struct packed {
    logic          action;
    logic [7:0]    src_x;
    logic [7:0]    src_y;
    logic [1:0]    channel;
    logic [7:0]    sample;
    logic [11:0]   dst_x;
    logic [11:0]   dst_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0] out_channel;
    logic [7:0] value;
    logic       last;
  } out_item_t;

  // classified command passed from front to back
  typedef struct packed {
    logic          is_write;
    logic [AW-1:0] waddr;
    logic [1:0]    wch;
    logic [7:0]    wdata;
    logic [XW-1:0] bx;
    logic [YW-1:0] by;
    logic [FracBits-1:0] fx;
    logic [FracBits-1:0] fy;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_FETCH, ST_HORNER, ST_VERT, ST_EMIT
  } back_state_t;
endpackage
`default_nettype wire

/* design/bir_stream_if.sv */
`default_nettype none
interface bir_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/bir_ram.sv */
`default_nettype none
module bir_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [Width/8-1:0]       wbe,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  // byte-enable write, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < Width / 8; i++) begin
        if (wbe[i]) mem[waddr][i*8 +: 8] <= wdata[i*8 +: 8];
      end
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/bir_front.sv */
`default_nettype none
module bir_front
  import bir_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [23:0] step_x,
  input  wire logic [23:0] step_y,
  input  wire logic [XW:0] w_eff,
  input  wire logic [YW:0] h_eff,
  bir_stream_if.sink       in_s,
  output logic             q_push,
  output cmd_t             q_data,
  input  wire logic        q_full
);
  // two-stage: register beat, then multiply and classify
  logic     s1_vld_r;
  in_item_t s1_r;
  logic [35:0] px, py;
  logic [35-FracBits:0] ix, iy;

  assign in_s.ready = !s1_vld_r || !q_full;
  assign q_push     = s1_vld_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_s.ready) begin
      s1_vld_r <= in_s.valid;
    end
    if (in_s.ready && in_s.valid) begin
      s1_r <= in_s.data;
    end
  end

  assign px = {12'd0, step_x} * {24'd0, s1_r.dst_x};
  assign py = {12'd0, step_y} * {24'd0, s1_r.dst_y};
  assign ix = px[35:FracBits];
  assign iy = py[35:FracBits];

  // classify and clamp base position
  always_comb begin
    q_data          = '0;
    q_data.is_write = (s1_r.action == ACT_WRITE);
    q_data.waddr    = {s1_r.src_y[YW-1:0], s1_r.src_x[XW-1:0]};
    q_data.wch      = s1_r.channel;
    q_data.wdata    = s1_r.sample;
    q_data.bx = (ix >= {{(36-FracBits-XW-1){1'b0}}, w_eff}) ?
                XW'(w_eff - 1'b1) : ix[XW-1:0];
    q_data.by = (iy >= {{(36-FracBits-YW-1){1'b0}}, h_eff}) ?
                YW'(h_eff - 1'b1) : iy[YW-1:0];
    q_data.fx = px[FracBits-1:0];
    q_data.fy = py[FracBits-1:0];
  end
endmodule
`default_nettype wire

/* design/bir_fifo.sv */
`default_nettype none
module bir_fifo
  import bir_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      wdata,
  output logic      full,
  input  wire logic pop,
  output cmd_t      rdata,
  output logic      empty
);
  // two-entry queue
  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rdata = mem_r[rp_r];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wp_r] <= wdata;
  end
endmodule
`default_nettype wire

/* design/bir_back.sv */
`default_nettype none
module bir_back
  import bir_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic [XW:0]  w_eff,
  input  wire logic [YW:0]  h_eff,
  input  wire logic [NCH_W-1:0] nch,
  input  cmd_t              q_data,
  input  wire logic         q_empty,
  output logic              q_pop,
  bir_stream_if.source      out_s
);
  back_state_t st_r, st_nxt;
  cmd_t        c_r;
  logic [3:0]  tap_r;       // neighbourhood index, row-major
  logic [3:0]  ptap;        // tap whose data is landing
  logic        rd_pend_r;
  logic [1:0]  row_r;       // row for horner / vertical slot
  logic [1:0]  hst_r;       // horner step
  logic [1:0]  ch_r;        // channel being worked / emitted
  logic        vert_r;
  logic [7:0]  nb_r [MaxChannels][4][4];
  logic signed [PW-1:0] col_r [MaxChannels][4];
  logic signed [PW-1:0] acc_r;
  logic signed [PW-1:0] k0, k1, k2, k3, c1, c2, c3, d0, d2, d3, cst;
  logic signed [PW+FracBits:0] prod;
  logic signed [PW-1:0] fl;
  logic [DW-1:0] rdata;
  logic [AW-1:0] raddr;
  logic [XW+1:0] tx; logic [YW+1:0] ty;
  logic [XW-1:0] cx; logic [YW-1:0] cy;
  logic       ram_we;
  logic [MaxChannels-1:0] wbe_q;
  logic [DW-1:0] wdat_q;
  logic signed [PW-1:0] vsel;
  logic [PW-ValShift-1:0] vt;
  logic [23:0] vm;
  logic [7:0]  vval;

  // clamped neighbour coordinate for the current tap
  always_comb begin
    tx = {2'b0, c_r.bx} + {{XW{1'b0}}, tap_r[1:0]} - 1'b1;
    ty = {2'b0, c_r.by} + {{YW{1'b0}}, tap_r[3:2]} - 1'b1;
    if (tx[XW+1]) cx = '0;
    else if (tx >= {1'b0, w_eff}) cx = XW'(w_eff - 1'b1);
    else cx = tx[XW-1:0];
    if (ty[YW+1]) cy = '0;
    else if (ty >= {1'b0, h_eff}) cy = YW'(h_eff - 1'b1);
    else cy = ty[YW-1:0];
    raddr = {cy, cx};
  end
  assign ptap = tap_r - 1'b1;

  // byte-lane write of one sample into the wide store word
  assign ram_we = (st_r == ST_IDLE) && !q_empty && q_data.is_write;
  assign wbe_q  = MaxChannels'(1) << q_data.wch;
  assign wdat_q = {MaxChannels{q_data.wdata}};

  bir_ram #(.Width(DW), .Depth(1 << AW)) u_ram (
    .clk(clk), .we(ram_we), .wbe(wbe_q), .waddr(q_data.waddr),
    .wdata(wdat_q), .raddr(raddr), .rdata(rdata)
  );

  // cubic coefficients (times 6) for the current row or column set
  always_comb begin
    if (vert_r) begin
      k0 = col_r[ch_r][0]; k1 = col_r[ch_r][1];
      k2 = col_r[ch_r][2]; k3 = col_r[ch_r][3];
    end else begin
      k0 = PW'(nb_r[ch_r][row_r][0]) <<< 16; k1 = PW'(nb_r[ch_r][row_r][1]) <<< 16;
      k2 = PW'(nb_r[ch_r][row_r][2]) <<< 16; k3 = PW'(nb_r[ch_r][row_r][3]) <<< 16;
    end
    d0 = k0 - k1; d2 = k2 - k1; d3 = k3 - k1;
    c1 = -(d0 <<< 1) + (d2 <<< 2) + (d2 <<< 1) - d3;
    c2 = (d0 <<< 1) + d0 + (d2 <<< 1) + d2;
    c3 = -d0 - (d2 <<< 1) - d2 + d3;
    case (hst_r)
      2'd0:    cst = c2;
      2'd1:    cst = c1;
      default: cst = (k1 <<< 2) + (k1 <<< 1);
    endcase
    prod = acc_r * $signed({1'b0, vert_r ? c_r.fy : c_r.fx});
    fl   = PW'(prod >>> FracBits);
  end

  // final value: negative gives 0, else floor(p / 2^18) / 9 saturated to 255
  always_comb begin
    vsel = col_r[ch_r][0];
    vt   = vsel[PW-1:ValShift];
    vm   = {12'd0, vt[11:0]} * 24'(Recip9);
    if (vsel < 0) vval = 8'd0;
    else if (vt >= (PW-ValShift)'(ValSat)) vval = 8'd255;
    else vval = vm[Recip9Shift +: 8];
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:   if (!q_empty && !q_data.is_write) st_nxt = ST_FETCH;
      ST_FETCH:  if (rd_pend_r && tap_r == 4'd0) st_nxt = ST_HORNER;
      ST_HORNER: if (hst_r == 2'd3 && row_r == 2'd3 &&
                     ch_r == 2'(nch - 1'b1)) st_nxt = ST_VERT;
      ST_VERT:   if (vert_r && hst_r == 2'd2 && ch_r == 2'(nch - 1'b1))
                   st_nxt = ST_EMIT;
      ST_EMIT:   if (out_s.ready && ch_r == 2'(nch - 1'b1)) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop      = (st_r == ST_IDLE) && !q_empty;
    out_s.valid = (st_r == ST_EMIT);
    out_s.data.out_channel = ch_r;
    out_s.data.value = vval;
    out_s.data.last = (ch_r == 2'(nch - 1'b1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else st_r <= st_nxt;
    case (st_r)
      ST_IDLE: begin
        c_r <= q_data; tap_r <= '0; rd_pend_r <= 1'b0;
        row_r <= '0; hst_r <= '0; ch_r <= '0; vert_r <= 1'b0;
      end
      ST_FETCH: begin
        // one tap per cycle; read data lands in the next cycle
        if (rd_pend_r) begin
          for (int c = 0; c < MaxChannels; c++)
            nb_r[c][ptap[3:2]][ptap[1:0]] <= rdata[c*8 +: 8];
        end
        tap_r <= tap_r + 1'b1;
        rd_pend_r <= 1'b1;
        if (rd_pend_r && tap_r == 4'd0) begin
          acc_r <= '0; hst_r <= 2'd3;
        end
      end
      ST_HORNER, ST_VERT: begin
        if (hst_r == 2'd3) begin
          acc_r <= c3; hst_r <= 2'd0;
        end else begin
          acc_r <= fl + cst;
          hst_r <= hst_r + 1'b1;
          if (hst_r == 2'd2) begin
            if (vert_r) begin
              col_r[ch_r][0] <= fl + cst;
              ch_r <= ch_r + 1'b1;
              hst_r <= 2'd3;
              if (ch_r == 2'(nch - 1'b1)) ch_r <= '0;
            end else begin
              col_r[ch_r][row_r] <= fl + cst;
              hst_r <= 2'd3;
              row_r <= row_r + 1'b1;
              if (row_r == 2'd3) begin
                ch_r <= ch_r + 1'b1;
                if (ch_r == 2'(nch - 1'b1)) begin
                  ch_r <= '0; vert_r <= 1'b1;
                end
              end
            end
          end
        end
      end
      ST_EMIT: if (out_s.ready) ch_r <= ch_r + 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* design/bicubic_image_resampler.sv */
`default_nettype none
// Bicubic resampler over a 256x256 store of up to four 8-bit channels held in
// one 32-bit word per pixel. Action 0 writes one sample and returns nothing;
// action 1 returns one beat per channel, channel 0 first, last on the final
// one. Once the back end takes a pixel request from the queue, it reads the
// neighbourhood (sixteen reads on the single store port, data registered),
// then runs the cubic passes on a shared multiplier (four horizontal rows per
// channel and one vertical pass per channel), then sends the result beats,
// which advance only while the receiver is ready. A write is done as the back
// end pops it from the queue. The front end adds an input register and a
// two-entry queue ahead of this. The store is not cleared at reset: read
// only samples that have been written.
module bicubic_image_resampler
  import bir_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0]    cfg_data,
  bir_stream_if.sink                in_s,
  bir_stream_if.source              out_s
);
  logic [8:0]  src_width_r, src_height_r;
  logic [2:0]  channels_r;
  logic [23:0] step_x_r, step_y_r;
  logic [XW:0] w_eff; logic [YW:0] h_eff; logic [NCH_W-1:0] nch;
  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_wdata, q_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r <= 9'd256; src_height_r <= 9'd256; channels_r <= 3'd1;
      step_x_r <= 24'd65536; step_y_r <= 24'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_width_r  <= cfg_data[8:0];
        REG_SRC_HEIGHT: src_height_r <= cfg_data[8:0];
        REG_CHANNELS:   channels_r   <= cfg_data[2:0];
        REG_STEP_X:     step_x_r     <= cfg_data;
        REG_STEP_Y:     step_y_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective limits: zero acts as one, above the store size acts as the size
  assign w_eff = (src_width_r == 9'd0) ? 9'd1 :
                 (src_width_r > 9'(MaxSrcWidth)) ? 9'(MaxSrcWidth) : src_width_r;
  assign h_eff = (src_height_r == 9'd0) ? 9'd1 :
                 (src_height_r > 9'(MaxSrcHeight)) ? 9'(MaxSrcHeight) : src_height_r;
  assign nch   = (channels_r == 3'd0) ? 3'd1 :
                 (channels_r > 3'(MaxChannels)) ? 3'(MaxChannels) : channels_r;

  bir_front u_front (
    .clk(clk), .rst_n(rst_n), .step_x(step_x_r), .step_y(step_y_r),
    .w_eff(w_eff), .h_eff(h_eff), .in_s(in_s),
    .q_push(q_push), .q_data(q_wdata), .q_full(q_full)
  );

  bir_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  bir_back u_back (
    .clk(clk), .rst_n(rst_n), .w_eff(w_eff), .h_eff(h_eff), .nch(nch),
    .q_data(q_rdata), .q_empty(q_empty), .q_pop(q_pop), .out_s(out_s)
  );
endmodule
`default_nettype wire

/* test/bicubic_image_resampler_tb.sv */
`timescale 1ns / 1ps
module bicubic_image_resampler_tb
  import bir_pkg::*;
();

  localparam int StoreSize = MaxSrcWidth * MaxSrcHeight * MaxChannels;
  localparam int Settle    = 200;
  localparam longint CycleLimit = 4000000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  bir_stream_if #(.T(in_item_t))  in_if();
  bir_stream_if #(.T(out_item_t)) out_if();

  bicubic_image_resampler u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_s(in_if.sink), .out_s(out_if.source)
  );

  // predictor state: image copy and effective register settings
  byte unsigned img_copy [StoreSize];
  int unsigned  eff_w, eff_h, eff_nch;
  logic [23:0]  cur_step_x, cur_step_y;
  // entries already scheduled for writing, tracked at generation time
  bit           planned [StoreSize];

  in_item_t  pending_beats [$];
  out_item_t expected_beats [$];

  int  mismatches;
  bit  in_taken;
  int  in_gap;
  int  out_hold;
  bit  long_stall;
  int  beats_seen;
  longint cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned lim(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic longint clampc(longint v, int unsigned l);
    if (v < 0) return 0;
    if (v >= longint'(l)) return longint'(l) - 1;
    return v;
  endfunction

  function automatic longint img_at(longint x, longint y, int unsigned c);
    int unsigned a;
    a = (int'(clampc(y, eff_h)) * MaxSrcWidth + int'(clampc(x, eff_w))) * MaxChannels + c;
    return longint'(img_copy[a]);
  endfunction

  // cubic through four points, base at p1, result scaled by six
  function automatic longint cubic6(longint p0, longint p1, longint p2, longint p3,
                                    longint f);
    longint d0, d2, d3, c1, c2, c3, p;
    d0 = p0 - p1; d2 = p2 - p1; d3 = p3 - p1;
    c1 = -2 * d0 + 6 * d2 - d3;
    c2 = 3 * d0 + 3 * d2;
    c3 = -d0 - 3 * d2 + d3;
    p = c3;
    p = ((p * f) >>> FracBits) + c2;
    p = ((p * f) >>> FracBits) + c1;
    p = ((p * f) >>> FracBits) + 6 * p1;
    return p;
  endfunction

  // expected beats for one accepted input beat; writes update the image copy
  function automatic void resample_pixel(in_item_t it);
    longint px, py, bx, by, fx, fy, p, q;
    longint col [4];
    out_item_t r;
    if (it.action == ACT_WRITE) begin
      img_copy[(int'(it.src_y) * MaxSrcWidth + int'(it.src_x)) * MaxChannels
               + int'(it.channel)] = it.sample;
      return;
    end
    px = longint'(cur_step_x) * longint'(it.dst_x);
    py = longint'(cur_step_y) * longint'(it.dst_y);
    bx = clampc(px >>> FracBits, eff_w);
    by = clampc(py >>> FracBits, eff_h);
    fx = px & 64'hFFFF;
    fy = py & 64'hFFFF;
    for (int k = 0; k < int'(eff_nch); k++) begin
      for (int j = 0; j < 4; j++)
        col[j] = cubic6(img_at(bx - 1, by - 1 + j, k) * 65536,
                        img_at(bx, by - 1 + j, k) * 65536,
                        img_at(bx + 1, by - 1 + j, k) * 65536,
                        img_at(bx + 2, by - 1 + j, k) * 65536, fx);
      p = cubic6(col[0], col[1], col[2], col[3], fy);
      if (p < 0) q = 0;
      else begin
        q = p / (36 * 65536);
        if (q > 255) q = 255;
      end
      r.out_channel = 2'(k);
      r.value = 8'(q);
      r.last = (k + 1 == int'(eff_nch));
      expected_beats.push_back(r);
    end
  endfunction

  // input side: driver at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_if.valid && !in_taken) begin
        // hold the offered beat
      end else if (in_gap > 0) begin
        in_if.valid <= 1'b0;
        in_gap--;
      end else if (pending_beats.size() > 0) begin
        in_if.data <= pending_beats.pop_front();
        in_if.valid <= 1'b1;
        in_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0) in_gap = 0;
      end else begin
        in_if.valid <= 1'b0;
      end
      in_taken = 1'b0;
    end
  end

  // input side: accepted beats feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      resample_pixel(in_if.data);
      in_taken = 1'b1;
    end
  end

  // result side: ready with random holds
  always @(negedge clk) begin
    if (rst_n) begin
      if (long_stall || out_hold > 0) begin
        out_if.ready <= 1'b0;
        if (!long_stall) out_hold--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // result side: compare each beat with the oldest expectation
  always @(posedge clk) begin
    out_item_t exp_b;
    if (rst_n && out_if.valid && out_if.ready) begin
      beats_seen++;
      out_hold = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: ch %0d value %0d last %0d",
                   out_if.data.out_channel, out_if.data.value, out_if.data.last);
      end else begin
        exp_b = expected_beats.pop_front();
        if (exp_b.out_channel !== out_if.data.out_channel ||
            exp_b.value !== out_if.data.value || exp_b.last !== out_if.data.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp ch %0d value %0d last %0d, got ch %0d value %0d last %0d",
                     exp_b.out_channel, exp_b.value, exp_b.last,
                     out_if.data.out_channel, out_if.data.value, out_if.data.last);
        end
      end
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    long_stall = 1'b0;
    wait (beats_seen >= 30);
    @(posedge clk);
    long_stall = 1'b1;
    repeat (800) @(posedge clk);
    long_stall = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("bicubic_image_resampler_tb: errors");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SRC_WIDTH:  eff_w = lim(32'(val[8:0]), MaxSrcWidth);
      REG_SRC_HEIGHT: eff_h = lim(32'(val[8:0]), MaxSrcHeight);
      REG_CHANNELS:   eff_nch = lim(32'(val[2:0]), MaxChannels);
      REG_STEP_X:     cur_step_x = val;
      REG_STEP_Y:     cur_step_y = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (pending_beats.size() == 0 && !in_if.valid && expected_beats.size() == 0);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic push_write(int x, int y, int c, int v);
    in_item_t it;
    it = '0;
    it.action = ACT_WRITE;
    it.src_x = 8'(x); it.src_y = 8'(y); it.channel = 2'(c); it.sample = 8'(v);
    it.dst_x = 12'($urandom); it.dst_y = 12'($urandom);
    planned[(y * MaxSrcWidth + x) * MaxChannels + c] = 1'b1;
    pending_beats.push_back(it);
  endtask

  task automatic push_pixel(int dx, int dy);
    in_item_t it;
    it.action = ACT_PIXEL;
    it.src_x = 8'($urandom); it.src_y = 8'($urandom);
    it.channel = 2'($urandom); it.sample = 8'($urandom);
    it.dst_x = 12'(dx); it.dst_y = 12'(dy);
    pending_beats.push_back(it);
  endtask

  function automatic int pick_sample();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // one setting: program registers, complete the read region, then random traffic
  task automatic run_phase(int w, int h, int nch, int sx, int sy, int n_pix);
    write_reg(REG_SRC_WIDTH, CFG_DW'(w));
    write_reg(REG_SRC_HEIGHT, CFG_DW'(h));
    write_reg(REG_CHANNELS, CFG_DW'(nch));
    write_reg(REG_STEP_X, CFG_DW'(sx));
    write_reg(REG_STEP_Y, CFG_DW'(sy));
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        for (int c = 0; c < nch; c++)
          if (!planned[(y * MaxSrcWidth + x) * MaxChannels + c])
            push_write(x, y, c, pick_sample());
    for (int i = 0; i < n_pix; i++) begin
      if ($urandom_range(0, 3) == 0)
        push_write($urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 3), pick_sample());
      else if ($urandom_range(0, 1) == 0)
        push_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
      else
        push_pixel($urandom_range(0, 15), $urandom_range(0, 15));
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    in_taken = 1'b0;
    in_gap = 0;
    out_hold = 0;
    mismatches = 0;
    beats_seen = 0;
    cycles = 0;
    eff_w = 256; eff_h = 256; eff_nch = 1;
    cur_step_x = 24'd65536; cur_step_y = 24'd65536;
    foreach (img_copy[i]) img_copy[i] = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: 2x2 image, channel count above four, hard edge for overshoot
    write_reg(REG_SRC_WIDTH, 24'd2);
    write_reg(REG_SRC_HEIGHT, 24'd2);
    write_reg(REG_CHANNELS, 24'd7);
    write_reg(REG_STEP_X, 24'h008000);
    write_reg(REG_STEP_Y, 24'h00C000);
    for (int y = 0; y < 2; y++)
      for (int x = 0; x < 2; x++)
        for (int c = 0; c < 4; c++)
          push_write(x, y, c, (((x + y + c) % 2) == 0) ? 255 : 0);
    push_pixel(0, 0);
    push_pixel(1, 1);
    push_pixel(3, 5);
    push_pixel(4095, 4095);
    push_pixel(4095, 0);
    push_write(300 % 256, 255, 3, 255);
    push_pixel(5, 2);
    push_pixel(2, 3);
    drain();

    run_phase(3, 3, 4, 65536, 65536, 20);
    run_phase(0, 0, 0, 0, 0, 10);
    run_phase(8, 1, 1, 24'hFFFFFF, 24'h012345, 15);
    run_phase(1, 8, 2, 24'h008000, 24'h02AAAA, 15);

    // width register above the store width acts as the store width
    write_reg(REG_SRC_WIDTH, 24'd300);
    write_reg(REG_SRC_HEIGHT, 24'd1);
    write_reg(REG_CHANNELS, 24'd1);
    write_reg(REG_STEP_X, 24'hFFFFFF);
    push_write(254, 0, 0, pick_sample());
    push_write(255, 0, 0, pick_sample());
    push_pixel(1, 0);
    push_pixel(2, 7);
    push_pixel(4095, 4095);
    push_pixel(1000, 3);
    drain();

    run_phase(5, 4, 3, $urandom_range(0, 24'h3FFFF), $urandom_range(0, 24'h3FFFF), 20);
    run_phase(4, 3, 2, $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'h3FFFF), 10);

    if (mismatches == 0 && expected_beats.size() == 0)
      $display("bicubic_image_resampler_tb: clean");
    else
      $display("bicubic_image_resampler_tb: errors");
    $finish;
  end
endmodule
